// ----- src/ps2k_pkg.sv -----
`default_nettype none

package ps2k_pkg;

    // Default sizing
    localparam int KEYMAP_DEPTH_DEF = 128;
    localparam int TICK_BITS_DEF    = 64;
    localparam int CFG_WIDTH        = 32;

    // Input operations
    typedef enum logic [1:0] {
        OP_SCAN      = 2'd0,
        OP_TICK      = 2'd1,
        OP_MAP_WRITE = 2'd2,
        OP_RESERVED  = 2'd3
    } opcode_t;

    // Configuration register indexes
    typedef enum logic [0:0] {
        REG_REPEAT_DELAY = 1'b0,
        REG_REPEAT_RATE  = 1'b1
    } cfg_index_t;

    // Result kinds
    typedef enum logic {
        KIND_KEY = 1'b0,
        KIND_CMD = 1'b1
    } kind_t;

    // Raw scan bytes
    localparam logic [7:0] SC_PREFIX = 8'hE0;
    localparam logic [7:0] SC_ACK    = 8'hFA;
    localparam logic [7:0] SC_RESEND = 8'hFE;
    localparam logic [7:0] SC_ECHO   = 8'hEE;
    localparam logic [7:0] SC_ERR_LO = 8'h00;
    localparam logic [7:0] SC_ERR_HI = 8'hFF;

    // Key codes (release bit stripped)
    localparam logic [6:0] KEY_CTRL   = 7'h1D;
    localparam logic [6:0] KEY_ALT    = 7'h38;
    localparam logic [6:0] KEY_LSHIFT = 7'h2A;
    localparam logic [6:0] KEY_RSHIFT = 7'h36;
    localparam logic [6:0] KEY_CAPS   = 7'h3A;
    localparam logic [6:0] KEY_NUM    = 7'h45;
    localparam logic [6:0] KEY_SCROLL = 7'h46;

    // Keyboard command and character range
    localparam logic [7:0] CMD_SET_LEDS = 8'hED;
    localparam logic [7:0] CHAR_LOW_A   = 8'h61;
    localparam logic [7:0] CHAR_LOW_Z   = 8'h7A;

    typedef struct packed {
        opcode_t    opcode;
        logic [7:0] scan_byte;
        logic [6:0] map_index;
        logic [7:0] map_base_char;
        logic [7:0] map_shifted_char;
    } cmd_item_t;

    typedef struct packed {
        kind_t      kind;
        logic [6:0] key_code;
        logic [7:0] character;
        logic [3:0] modifiers;
        logic [7:0] device_byte;
        logic       last_of_run;
    } evt_item_t;

    typedef struct packed {
        logic [7:0] shifted_char;
        logic [7:0] base_char;
    } map_entry_t;

    typedef struct packed {
        logic      valid;
        evt_item_t item;
    } evt_push_t;

endpackage

`default_nettype wire

// ----- src/ps2k_if.sv -----
`default_nettype none

// Input channel
interface ps2k_cmd_if;
    import ps2k_pkg::*;
    logic      valid;
    logic      ready;
    cmd_item_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// Result channel
interface ps2k_evt_if;
    import ps2k_pkg::*;
    logic      valid;
    logic      ready;
    evt_item_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// ----- src/ps2k_keymap.sv -----
`default_nettype none

module ps2k_keymap #(
    parameter int KEYMAP_DEPTH = ps2k_pkg::KEYMAP_DEPTH_DEF
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   accept,
    input  wire ps2k_pkg::cmd_item_t    item,
    output ps2k_pkg::map_entry_t        rd_entry
);
    import ps2k_pkg::*;

    localparam int         AW      = $clog2(KEYMAP_DEPTH);
    localparam logic [7:0] DEPTH_W = 8'(KEYMAP_DEPTH);

    map_entry_t              mem [KEYMAP_DEPTH];
    logic [KEYMAP_DEPTH-1:0] valid_reg;
    map_entry_t              rd_data_reg;
    logic                    rd_live_reg;

    logic       wr_hit;
    logic       rd_en;
    logic [6:0] rd_key;
    logic       rd_in_range;
    map_entry_t wr_entry;

    assign wr_hit      = accept && (item.opcode == OP_MAP_WRITE)
                         && ({1'b0, item.map_index} < DEPTH_W);
    assign rd_en       = accept && (item.opcode == OP_SCAN);
    assign rd_key      = item.scan_byte[6:0];
    assign rd_in_range = {1'b0, rd_key} < DEPTH_W;
    assign wr_entry    = '{shifted_char: item.map_shifted_char, base_char: item.map_base_char};

    // Keymap storage, registered read
    always_ff @(posedge clk)
    begin
        if (wr_hit)
        begin
            mem[item.map_index[AW-1:0]] <= wr_entry;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_key[AW-1:0]];
        end
    end

    // Per-entry written flags; unwritten entries read as zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg   <= '0;
            rd_live_reg <= 1'b0;
        end
        else
        begin
            if (wr_hit)
            begin
                valid_reg[item.map_index[AW-1:0]] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_live_reg <= rd_in_range && valid_reg[rd_key[AW-1:0]];
            end
        end
    end

    assign rd_entry = rd_live_reg ? rd_data_reg : '0;

endmodule

`default_nettype wire

// ----- src/ps2k_decode.sv -----
`default_nettype none

module ps2k_decode #(
    parameter int TICK_BITS = ps2k_pkg::TICK_BITS_DEF
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              accept,
    input  wire ps2k_pkg::cmd_item_t               item,
    input  wire ps2k_pkg::map_entry_t              map_entry,
    input  wire logic [ps2k_pkg::CFG_WIDTH-1:0]    repeat_delay,
    input  wire logic [ps2k_pkg::CFG_WIDTH-1:0]    repeat_rate,
    input  wire logic                              push_room,
    output logic                                   take,
    output ps2k_pkg::evt_push_t                    push
);
    import ps2k_pkg::*;

    // Stage register
    logic      s1_valid_reg;
    cmd_item_t s1_item_reg;

    // Decoder state
    logic                 prefix_reg, prefix_next;
    logic                 shift_reg, shift_next;
    logic                 ctrl_reg, ctrl_next;
    logic                 alt_reg, alt_next;
    logic [2:0]           lock_reg, lock_next;
    logic [2:0]           shadow_reg, shadow_next;
    logic                 led_pending_reg, led_pending_next;
    logic                 active_reg, active_next;
    logic [7:0]           rep_key_reg, rep_key_next;
    logic [6:0]           rep_code_reg, rep_code_next;
    logic [7:0]           rep_char_reg, rep_char_next;
    logic [3:0]           rep_mods_reg, rep_mods_next;
    logic [TICK_BITS-1:0] tick_now_reg, tick_now_next;
    logic [TICK_BITS-1:0] tick_inc_reg, tick_inc_next;
    logic [TICK_BITS-1:0] due_reg, due_next;

    logic       step;
    logic       release_s1;
    logic       rel;
    logic [6:0] key;
    logic [7:0] b;
    logic [2:0] mods_now;
    logic       is_letter;
    logic       sel;
    logic [7:0] ch;
    logic [2:0] lock_mask;
    logic [2:0] lock_toggled;
    logic [2:0] led_bits;

    assign step       = s1_valid_reg && push_room;
    assign release_s1 = step && !led_pending_next;
    assign take       = !s1_valid_reg || release_s1;

    // Field decode and translation
    assign b            = s1_item_reg.scan_byte;
    assign rel          = b[7];
    assign key          = b[6:0];
    assign mods_now     = {alt_reg, ctrl_reg, shift_reg};
    assign is_letter    = (map_entry.base_char >= CHAR_LOW_A)
                          && (map_entry.base_char <= CHAR_LOW_Z);
    assign sel          = is_letter ? (lock_reg[0] ^ shift_reg) : shift_reg;
    assign ch           = sel ? map_entry.shifted_char : map_entry.base_char;
    assign lock_mask    = {key == KEY_SCROLL, key == KEY_NUM, key == KEY_CAPS};
    assign lock_toggled = lock_reg ^ lock_mask;
    assign led_bits     = {lock_toggled[0], lock_toggled[1], lock_toggled[2]};

    // Next state and result
    always_comb
    begin
        prefix_next      = prefix_reg;
        shift_next       = shift_reg;
        ctrl_next        = ctrl_reg;
        alt_next         = alt_reg;
        lock_next        = lock_reg;
        shadow_next      = shadow_reg;
        led_pending_next = led_pending_reg;
        active_next      = active_reg;
        rep_key_next     = rep_key_reg;
        rep_code_next    = rep_code_reg;
        rep_char_next    = rep_char_reg;
        rep_mods_next    = rep_mods_reg;
        tick_now_next    = tick_now_reg;
        tick_inc_next    = tick_inc_reg;
        due_next         = due_reg;
        push             = '0;

        if (step && led_pending_reg)
        begin
            // second beat of the LED command
            push.valid            = 1'b1;
            push.item.kind        = KIND_CMD;
            push.item.device_byte = {5'd0, shadow_reg};
            push.item.last_of_run = 1'b1;
            led_pending_next      = 1'b0;
        end
        else if (step)
        begin
            unique case (s1_item_reg.opcode) inside
                OP_SCAN:
                begin
                    if (b == SC_PREFIX)
                    begin
                        prefix_next = 1'b1;
                    end
                    else if (b == SC_ACK || b == SC_RESEND || b == SC_ECHO)
                    begin
                        prefix_next = prefix_reg;
                    end
                    else if (b == SC_ERR_LO || b == SC_ERR_HI)
                    begin
                        prefix_next = 1'b0;
                        active_next = 1'b0;
                        shift_next  = 1'b0;
                        ctrl_next   = 1'b0;
                        alt_next    = 1'b0;
                    end
                    else if (prefix_reg)
                    begin
                        prefix_next = 1'b0;
                        if (key == KEY_CTRL)
                        begin
                            ctrl_next = !rel;
                        end
                        else if (key == KEY_ALT)
                        begin
                            alt_next = !rel;
                        end
                        else if (rel)
                        begin
                            if (active_reg && rep_key_reg == {1'b1, key})
                            begin
                                active_next = 1'b0;
                            end
                        end
                        else
                        begin
                            rep_key_next          = {1'b1, key};
                            rep_code_next         = key;
                            rep_char_next         = 8'd0;
                            rep_mods_next         = {1'b1, mods_now};
                            due_next              = tick_now_reg + TICK_BITS'(repeat_delay);
                            active_next           = 1'b1;
                            push.valid            = 1'b1;
                            push.item.kind        = KIND_KEY;
                            push.item.key_code    = key;
                            push.item.modifiers   = {1'b1, mods_now};
                            push.item.last_of_run = 1'b1;
                        end
                    end
                    else if (key == KEY_LSHIFT || key == KEY_RSHIFT)
                    begin
                        shift_next = !rel;
                    end
                    else if (key == KEY_CTRL)
                    begin
                        ctrl_next = !rel;
                    end
                    else if (key == KEY_ALT)
                    begin
                        alt_next = !rel;
                    end
                    else if (!rel && lock_mask != 3'd0)
                    begin
                        lock_next = lock_toggled;
                        if (led_bits != shadow_reg)
                        begin
                            shadow_next           = led_bits;
                            led_pending_next      = 1'b1;
                            push.valid            = 1'b1;
                            push.item.kind        = KIND_CMD;
                            push.item.device_byte = CMD_SET_LEDS;
                        end
                    end
                    else if (rel)
                    begin
                        if (active_reg && rep_key_reg == {1'b0, key})
                        begin
                            active_next = 1'b0;
                        end
                    end
                    else if (ch != 8'd0)
                    begin
                        rep_key_next          = {1'b0, key};
                        rep_code_next         = key;
                        rep_char_next         = ch;
                        rep_mods_next         = {1'b0, mods_now};
                        due_next              = tick_now_reg + TICK_BITS'(repeat_delay);
                        active_next           = 1'b1;
                        push.valid            = 1'b1;
                        push.item.kind        = KIND_KEY;
                        push.item.key_code    = key;
                        push.item.character   = ch;
                        push.item.modifiers   = {1'b0, mods_now};
                        push.item.last_of_run = 1'b1;
                    end
                end
                OP_TICK:
                begin
                    tick_now_next = tick_inc_reg;
                    tick_inc_next = tick_inc_reg + TICK_BITS'(1);
                    if (active_reg && tick_inc_reg >= due_reg)
                    begin
                        due_next              = tick_inc_reg + TICK_BITS'(repeat_rate);
                        push.valid            = 1'b1;
                        push.item.kind        = KIND_KEY;
                        push.item.key_code    = rep_code_reg;
                        push.item.character   = rep_char_reg;
                        push.item.modifiers   = rep_mods_reg;
                        push.item.last_of_run = 1'b1;
                    end
                end
                OP_MAP_WRITE, OP_RESERVED:
                begin
                    prefix_next = prefix_reg;
                end
                default:
                begin
                    prefix_next = prefix_reg;
                end
            endcase
        end
    end

    // Stage payload
    always_ff @(posedge clk)
    begin
        if (take && accept)
        begin
            s1_item_reg <= item;
        end
    end

    // Control and decoder state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg    <= 1'b0;
            prefix_reg      <= 1'b0;
            shift_reg       <= 1'b0;
            ctrl_reg        <= 1'b0;
            alt_reg         <= 1'b0;
            lock_reg        <= 3'd0;
            shadow_reg      <= 3'd0;
            led_pending_reg <= 1'b0;
            active_reg      <= 1'b0;
            rep_key_reg     <= 8'd0;
            rep_code_reg    <= 7'd0;
            rep_char_reg    <= 8'd0;
            rep_mods_reg    <= 4'd0;
            tick_now_reg    <= '0;
            tick_inc_reg    <= TICK_BITS'(1);
            due_reg         <= '0;
        end
        else
        begin
            if (take)
            begin
                s1_valid_reg <= accept;
            end
            prefix_reg      <= prefix_next;
            shift_reg       <= shift_next;
            ctrl_reg        <= ctrl_next;
            alt_reg         <= alt_next;
            lock_reg        <= lock_next;
            shadow_reg      <= shadow_next;
            led_pending_reg <= led_pending_next;
            active_reg      <= active_next;
            rep_key_reg     <= rep_key_next;
            rep_code_reg    <= rep_code_next;
            rep_char_reg    <= rep_char_next;
            rep_mods_reg    <= rep_mods_next;
            tick_now_reg    <= tick_now_next;
            tick_inc_reg    <= tick_inc_next;
            due_reg         <= due_next;
        end
    end

    // An LED beat still owed keeps its item in the stage
    a_pending_holds_item: assert property (@(posedge clk) disable iff (!rst_n)
        led_pending_reg |-> s1_valid_reg)
        else $error("LED beat pending without an item in stage");

    a_pending_one_beat: assert property (@(posedge clk) disable iff (!rst_n)
        (led_pending_reg && push_room) |=> !led_pending_reg)
        else $error("LED beat pending longer than one push");

    a_tick_inc_tracks: assert property (@(posedge clk) disable iff (!rst_n)
        tick_inc_reg == tick_now_reg + TICK_BITS'(1))
        else $error("tick increment register out of step");

endmodule

`default_nettype wire

// ----- src/ps2k_out_queue.sv -----
`default_nettype none

module ps2k_out_queue (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire ps2k_pkg::evt_push_t  push,
    output logic                      room,
    ps2k_evt_if.source                evt
);
    import ps2k_pkg::*;

    evt_item_t  slot_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic       pop;

    assign pop       = evt.valid && evt.ready;
    assign evt.valid = count_reg != 2'd0;
    assign evt.data  = slot_reg[rd_ptr_reg];
    assign room      = (count_reg != 2'd2) || evt.ready;

    // Result slots
    always_ff @(posedge clk)
    begin
        if (push.valid)
        begin
            slot_reg[wr_ptr_reg] <= push.item;
        end
    end

    // Pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push.valid)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            case ({push.valid, pop})
                2'b10:   count_reg <= count_reg + 2'd1;
                2'b01:   count_reg <= count_reg - 2'd1;
                default: count_reg <= count_reg;
            endcase
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= 2'd2)
        else $error("result queue count out of range");

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(push.valid && count_reg == 2'd2 && !pop))
        else $error("result pushed into a full queue");

endmodule

`default_nettype wire

// ----- src/ps2_scancode_decoder_with_repeat.sv -----
// Path: keymap read and stage load happen on the edge that takes the input beat;
// the decode is then written into the result queue, which offers the result beat.
// Throughput: one input beat per cycle; a lock key that changes the LEDs holds the
// decode stage for its second command beat; a full result queue without ready stalls
// the stage. Reset: all control state clears at once; keymap written-flags clear on
// reset, so every entry reads as zero with no clearing pass.
`default_nettype none

module ps2_scancode_decoder_with_repeat #(
    parameter int KEYMAP_DEPTH = ps2k_pkg::KEYMAP_DEPTH_DEF,
    parameter int TICK_BITS    = ps2k_pkg::TICK_BITS_DEF
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    ps2k_cmd_if.sink                             cmd,
    ps2k_evt_if.source                           evt,
    input  wire logic                            cfg_write,
    input  wire ps2k_pkg::cfg_index_t            cfg_index,
    input  wire logic [ps2k_pkg::CFG_WIDTH-1:0]  cfg_data
);
    import ps2k_pkg::*;

    logic [CFG_WIDTH-1:0] repeat_delay_reg;
    logic [CFG_WIDTH-1:0] repeat_rate_reg;

    logic       accept;
    logic       take;
    logic       room;
    map_entry_t map_entry;
    evt_push_t  push;

    assign cmd.ready = take;
    assign accept    = cmd.valid && take;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            repeat_delay_reg <= CFG_WIDTH'(500);
            repeat_rate_reg  <= CFG_WIDTH'(33);
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_REPEAT_DELAY: repeat_delay_reg <= cfg_data;
                REG_REPEAT_RATE:  repeat_rate_reg  <= cfg_data;
                default:          repeat_rate_reg  <= repeat_rate_reg;
            endcase
        end
    end

    ps2k_keymap #(
        .KEYMAP_DEPTH (KEYMAP_DEPTH)
    ) u_keymap (
        .clk      (clk),
        .rst_n    (rst_n),
        .accept   (accept),
        .item     (cmd.data),
        .rd_entry (map_entry)
    );

    ps2k_decode #(
        .TICK_BITS (TICK_BITS)
    ) u_decode (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (accept),
        .item         (cmd.data),
        .map_entry    (map_entry),
        .repeat_delay (repeat_delay_reg),
        .repeat_rate  (repeat_rate_reg),
        .push_room    (room),
        .take         (take),
        .push         (push)
    );

    ps2k_out_queue u_out_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .room  (room),
        .evt   (evt)
    );

endmodule

`default_nettype wire

// ----- sim/ps2k_event_checker.sv -----
// Watches the scan/tick/keymap channel and the event channel, decodes every
// input beat on its own copy of the keyboard state and compares each event
// beat against the oldest decoded result.
module ps2k_event_checker #(
    parameter int KEYMAP_DEPTH = ps2k_pkg::KEYMAP_DEPTH_DEF,
    parameter int TICK_BITS    = ps2k_pkg::TICK_BITS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    ps2k_cmd_if                            cmd,
    ps2k_evt_if                            evt,
    input  logic                           cfg_write,
    input  ps2k_pkg::cfg_index_t           cfg_index,
    input  logic [ps2k_pkg::CFG_WIDTH-1:0] cfg_data,
    output int                             mismatches,
    output int                             outstanding,
    output int                             checked
);
    timeunit 1ns;
    timeprecision 1ps;

    import ps2k_pkg::*;

    // Typematic settings
    logic [31:0] repeat_delay;
    logic [31:0] repeat_rate;

    // Keyboard state
    logic                 prefix_seen;
    logic                 shift_held;
    logic                 ctrl_held;
    logic                 alt_held;
    logic [2:0]           lock_flags;     // bit0 caps, bit1 num, bit2 scroll
    logic [2:0]           led_sent;
    logic                 repeat_on;
    logic [7:0]           repeat_id;      // {extended, key}
    evt_item_t            repeat_beat;
    logic [TICK_BITS-1:0] tick_count;
    logic [TICK_BITS-1:0] repeat_due;
    map_entry_t           keymap [KEYMAP_DEPTH];

    evt_item_t decoded_out [$];
    int        fail_total;
    int        beats_seen;

    function automatic evt_item_t make_beat(kind_t kind, logic [6:0] code, logic [7:0] ch,
                                            logic [3:0] mods, logic [7:0] dev, logic last);
        evt_item_t e;
        e.kind        = kind;
        e.key_code    = code;
        e.character   = ch;
        e.modifiers   = mods;
        e.device_byte = dev;
        e.last_of_run = last;
        return e;
    endfunction

    function automatic string show(evt_item_t e);
        return $sformatf("kind=%0d key=%02h char=%02h mods=%01h dev=%02h last=%0d",
                         e.kind, e.key_code, e.character, e.modifiers, e.device_byte,
                         e.last_of_run);
    endfunction

    function automatic logic [7:0] lookup_char(logic [6:0] key);
        map_entry_t e;
        logic       pick_shifted;
        if (int'(key) >= KEYMAP_DEPTH)
            return 8'h00;
        e = keymap[key];
        pick_shifted = shift_held;
        // lower-case letters follow caps lock, inverted by shift
        if (e.base_char >= CHAR_LOW_A && e.base_char <= CHAR_LOW_Z)
            pick_shifted = lock_flags[0] ^ shift_held;
        return pick_shifted ? e.shifted_char : e.base_char;
    endfunction

    // Key press: emit its event and hold it for typematic repeat
    task automatic arm_repeat(logic ext, logic [6:0] key, logic [7:0] ch, logic [3:0] mods);
        repeat_id   = {ext, key};
        repeat_beat = make_beat(KIND_KEY, key, ch, mods, 8'h00, 1'b1);
        repeat_due  = tick_count + TICK_BITS'(repeat_delay);
        repeat_on   = 1'b1;
        decoded_out.push_back(repeat_beat);
    endtask

    task automatic decode_input(cmd_item_t c);
        logic [7:0] b;
        logic [6:0] key;
        logic       brk;
        logic [7:0] ch;
        logic [2:0] led;
        b   = c.scan_byte;
        key = b[6:0];
        brk = b[7];

        // Timer tick: advance, then re-issue the held key once due
        if (c.opcode == OP_TICK) begin
            tick_count = tick_count + 1'b1;
            if (repeat_on && tick_count >= repeat_due) begin
                repeat_due = tick_count + TICK_BITS'(repeat_rate);
                decoded_out.push_back(repeat_beat);
            end
            return;
        end
        if (c.opcode == OP_MAP_WRITE) begin
            if (int'(c.map_index) < KEYMAP_DEPTH)
                keymap[c.map_index] = {c.map_shifted_char, c.map_base_char};
            return;
        end
        if (c.opcode != OP_SCAN)
            return;

        if (b == SC_PREFIX) begin
            prefix_seen = 1'b1;
            return;
        end
        // link replies are dropped; a pending prefix survives them
        if (b == SC_ACK || b == SC_RESEND || b == SC_ECHO)
            return;
        // error bytes drop prefix, modifiers and repeat
        if (b == SC_ERR_LO || b == SC_ERR_HI) begin
            prefix_seen = 1'b0;
            repeat_on   = 1'b0;
            shift_held  = 1'b0;
            ctrl_held   = 1'b0;
            alt_held    = 1'b0;
            return;
        end

        // Extended keys
        if (prefix_seen) begin
            prefix_seen = 1'b0;
            if (key == KEY_CTRL)
                ctrl_held = !brk;
            else if (key == KEY_ALT)
                alt_held = !brk;
            else if (brk) begin
                if (repeat_on && repeat_id == {1'b1, key})
                    repeat_on = 1'b0;
            end
            else
                arm_repeat(1'b1, key, 8'h00, {1'b1, alt_held, ctrl_held, shift_held});
            return;
        end

        // Plain keys
        if (key == KEY_LSHIFT || key == KEY_RSHIFT)
            shift_held = !brk;
        else if (key == KEY_CTRL)
            ctrl_held = !brk;
        else if (key == KEY_ALT)
            alt_held = !brk;
        else if (!brk && (key == KEY_CAPS || key == KEY_NUM || key == KEY_SCROLL)) begin
            if (key == KEY_CAPS)
                lock_flags[0] = ~lock_flags[0];
            else if (key == KEY_NUM)
                lock_flags[1] = ~lock_flags[1];
            else
                lock_flags[2] = ~lock_flags[2];
            // LED bits: scroll 1, num 2, caps 4; sent only when they change
            led = {lock_flags[0], lock_flags[1], lock_flags[2]};
            if (led != led_sent) begin
                led_sent = led;
                decoded_out.push_back(make_beat(KIND_CMD, 7'h00, 8'h00, 4'h0,
                                                CMD_SET_LEDS, 1'b0));
                decoded_out.push_back(make_beat(KIND_CMD, 7'h00, 8'h00, 4'h0,
                                                {5'b00000, led}, 1'b1));
            end
        end
        else if (brk) begin
            if (repeat_on && repeat_id == {1'b0, key})
                repeat_on = 1'b0;
        end
        else begin
            ch = lookup_char(key);
            if (ch != 8'h00)
                arm_repeat(1'b0, key, ch, {1'b0, alt_held, ctrl_held, shift_held});
        end
    endtask

    always @(posedge clk or negedge rst_n) begin
        evt_item_t want;
        if (!rst_n) begin
            repeat_delay = 32'd500;
            repeat_rate  = 32'd33;
            prefix_seen  = 1'b0;
            shift_held   = 1'b0;
            ctrl_held    = 1'b0;
            alt_held     = 1'b0;
            lock_flags   = 3'b000;
            led_sent     = 3'b000;
            repeat_on    = 1'b0;
            repeat_id    = 8'h00;
            repeat_beat  = '0;
            tick_count   = '0;
            repeat_due   = '0;
            for (int i = 0; i < KEYMAP_DEPTH; i++)
                keymap[i] = '0;
            decoded_out.delete();
            fail_total   = 0;
            beats_seen   = 0;
        end
        else begin
            if (cfg_write) begin
                if (cfg_index == REG_REPEAT_DELAY)
                    repeat_delay = cfg_data;
                else
                    repeat_rate = cfg_data;
            end

            // Result beat against the oldest decoded result
            if (evt.valid && evt.ready) begin
                beats_seen++;
                if (decoded_out.size() == 0) begin
                    fail_total++;
                    if (fail_total <= 10)
                        $display("%0t: event beat with nothing pending: %s",
                                 $realtime, show(evt.data));
                end
                else begin
                    want = decoded_out.pop_front();
                    if (evt.data.kind !== want.kind || evt.data.key_code !== want.key_code ||
                        evt.data.character !== want.character ||
                        evt.data.modifiers !== want.modifiers ||
                        evt.data.device_byte !== want.device_byte ||
                        evt.data.last_of_run !== want.last_of_run) begin
                        fail_total++;
                        if (fail_total <= 10)
                            $display("%0t: event mismatch\n  expected %s\n  actual   %s",
                                     $realtime, show(want), show(evt.data));
                    end
                end
            end

            if (cmd.valid && cmd.ready)
                decode_input(cmd.data);
        end
        mismatches  <= fail_total;
        outstanding <= decoded_out.size();
        checked     <= beats_seen;
    end

endmodule

// ----- sim/tb_top.sv -----
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import ps2k_pkg::*;

    localparam int NUM_SETTINGS    = 7;
    localparam int ITEMS_PER_PHASE = 75;
    localparam int SETTLE_CYCLES   = 6;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_write;
    cfg_index_t           cfg_index;
    logic [CFG_WIDTH-1:0] cfg_data;

    int mismatches;
    int outstanding;
    int checked;
    int items_sent;
    bit send_burst;
    bit take_burst;

    // Typematic settings per random phase, extremes included
    logic [31:0] phase_delay [NUM_SETTINGS] =
        '{32'd0, 32'd3, 32'd1, 32'hFFFF_FFFF, 32'd5, 32'd0, 32'd500};
    logic [31:0] phase_rate [NUM_SETTINGS] =
        '{32'd0, 32'd2, 32'd7, 32'hFFFF_FFFF, 32'd0, 32'hFFFF_FFFF, 32'd33};

    ps2k_cmd_if cmd_ch ();
    ps2k_evt_if evt_ch ();

    ps2_scancode_decoder_with_repeat dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd_ch),
        .evt       (evt_ch),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    ps2k_event_checker event_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd_ch),
        .evt         (evt_ch),
        .cfg_write   (cfg_write),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .mismatches  (mismatches),
        .outstanding (outstanding),
        .checked     (checked)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Fields the opcode does not use carry random junk
    function automatic cmd_item_t blank_item(opcode_t op);
        cmd_item_t  c;
        logic [63:0] raw;
        raw = {$urandom, $urandom};
        c = raw[$bits(cmd_item_t)-1:0];
        c.opcode = op;
        return c;
    endfunction

    task automatic send_item(cmd_item_t c);
        int gap;
        if ($urandom_range(0, 24) == 0)
            send_burst = !send_burst;
        gap = send_burst ? 0 : $urandom_range(0, 11);
        if (gap > 0) begin
            cmd_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cmd_ch.valid <= 1'b1;
        cmd_ch.data  <= c;
        @(posedge clk);
        while (!cmd_ch.ready)
            @(posedge clk);
        items_sent++;
    endtask

    task automatic send_scan(logic [7:0] b);
        cmd_item_t c;
        c = blank_item(OP_SCAN);
        c.scan_byte = b;
        send_item(c);
    endtask

    task automatic send_ticks(int n);
        for (int i = 0; i < n; i++)
            send_item(blank_item(OP_TICK));
    endtask

    task automatic send_map(logic [6:0] idx, logic [7:0] base, logic [7:0] shifted);
        cmd_item_t c;
        c = blank_item(OP_MAP_WRITE);
        c.map_index        = idx;
        c.map_base_char    = base;
        c.map_shifted_char = shifted;
        send_item(c);
    endtask

    // Drain: every decoded result back, then let silent beats clear the pipe
    task automatic wait_idle();
        cmd_ch.valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic program_repeat(logic [31:0] delay, logic [31:0] rate);
        cfg_write <= 1'b1;
        cfg_index <= REG_REPEAT_DELAY;
        cfg_data  <= delay;
        @(posedge clk);
        cfg_index <= REG_REPEAT_RATE;
        cfg_data  <= rate;
        @(posedge clk);
        cfg_write <= 1'b0;
    endtask

    // Event sink with random stalls and stall-free stretches
    initial
    begin
        int stall;
        evt_ch.ready = 1'b0;
        wait (rst_n === 1'b1);
        forever begin
            if ($urandom_range(0, 29) == 0)
                take_burst = !take_burst;
            stall = take_burst ? 0 : $urandom_range(0, 11);
            if (stall > 0) begin
                evt_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            evt_ch.ready <= 1'b1;
            @(posedge clk);
            while (!(evt_ch.valid && evt_ch.ready))
                @(posedge clk);
        end
    end

    initial
    begin
        #2_000_000;
        $display("simulation failed");
        $finish;
    end

    // Stimulus
    initial
    begin
        int         phase_start;
        int         pick;
        logic [6:0] key;
        logic [7:0] base;

        rst_n        = 1'b0;
        cmd_ch.valid = 1'b0;
        cmd_ch.data  = '0;
        cfg_write    = 1'b0;
        cfg_index    = REG_REPEAT_DELAY;
        cfg_data     = '0;
        items_sent   = 0;
        send_burst   = 1'b0;
        take_burst   = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: short repeat so the first repeat shows within two ticks
        program_repeat(32'd2, 32'd1);
        send_map(7'h1E, 8'h61, 8'h41);
        send_map(7'h02, 8'h31, 8'h21);
        send_map(7'h7F, 8'hFF, 8'h00);
        send_map(7'h00, 8'h00, 8'hFF);
        send_scan(8'h1E);               // 'a'
        send_ticks(2);                  // first repeat
        send_scan(8'h9E);
        send_scan(8'h2A);               // shift + letter
        send_scan(8'h1E);
        send_scan(8'hAA);
        send_scan(8'h3A);               // caps: LED command pair
        send_scan(8'h1E);               // caps letter
        send_scan(8'h02);               // caps leaves digits alone
        send_scan(8'h45);
        send_scan(8'h46);
        send_scan(SC_PREFIX);           // extended ctrl and alt
        send_scan(8'h1D);
        send_scan(SC_PREFIX);
        send_scan(8'h38);
        send_scan(SC_PREFIX);           // prefix survives an ack
        send_scan(SC_ACK);
        send_scan(8'h48);
        send_ticks(1);
        send_scan(SC_ERR_LO);
        send_scan(8'h7F);               // top key code, top character
        send_scan(SC_ERR_HI);
        send_item(blank_item(OP_RESERVED));

        // Random phases, one per typematic setting
        for (int p = 0; p < NUM_SETTINGS; p++) begin
            wait_idle();
            program_repeat(phase_delay[p], phase_rate[p]);
            phase_start = items_sent;
            while (items_sent - phase_start < ITEMS_PER_PHASE) begin
                if ($urandom_range(0, 49) == 0)
                    wait_idle();
                // most presses hit a small pool that keymap writes also favor
                key = ($urandom_range(0, 3) != 0) ? 7'($urandom_range(8'h10, 8'h32))
                                                  : 7'($urandom_range(0, 127));
                pick = $urandom_range(0, 99);
                if (pick < 15) begin
                    case ($urandom_range(0, 9))
                        0:       base = 8'h00;
                        1, 2, 3: base = 8'($urandom);
                        default: base = 8'($urandom_range(CHAR_LOW_A, CHAR_LOW_Z));
                    endcase
                    send_map(key, base, 8'($urandom));
                end
                else if (pick < 40)
                    send_ticks($urandom_range(1, 6));
                else if (pick < 60) begin
                    send_scan({1'b0, key});
                    send_ticks($urandom_range(0, 5));
                    if ($urandom_range(0, 3) != 0)
                        send_scan({1'b1, key});
                end
                else if (pick < 70) begin
                    send_scan(SC_PREFIX);
                    send_scan({1'b0, key});
                    send_ticks($urandom_range(0, 5));
                    if ($urandom_range(0, 3) != 0) begin
                        send_scan(SC_PREFIX);
                        send_scan({1'b1, key});
                    end
                end
                else if (pick < 80) begin
                    case ($urandom_range(0, 5))
                        0:       key = KEY_LSHIFT;
                        1:       key = KEY_RSHIFT;
                        2, 4:    key = KEY_CTRL;
                        default: key = KEY_ALT;
                    endcase
                    if ($urandom_range(0, 2) == 0)
                        send_scan(SC_PREFIX);
                    send_scan({1'($urandom_range(0, 1)), key});
                end
                else if (pick < 88) begin
                    case ($urandom_range(0, 2))
                        0:       key = KEY_CAPS;
                        1:       key = KEY_NUM;
                        default: key = KEY_SCROLL;
                    endcase
                    send_scan({1'b0, key});
                    if ($urandom_range(0, 1) == 0)
                        send_scan({1'b1, key});
                end
                else begin
                    // noise and broken sequences
                    case ($urandom_range(0, 5))
                        0: send_scan(8'($urandom));
                        1: send_scan($urandom_range(0, 2) == 0 ? SC_ACK :
                                     $urandom_range(0, 1) == 0 ? SC_RESEND : SC_ECHO);
                        2: send_scan($urandom_range(0, 1) == 0 ? SC_ERR_LO : SC_ERR_HI);
                        3: send_item(blank_item(OP_RESERVED));
                        4: send_scan(SC_PREFIX);
                        default:
                        begin
                            send_scan(SC_PREFIX);
                            send_scan(SC_RESEND);
                            send_scan({1'b0, key});
                        end
                    endcase
                end
            end
        end

        wait_idle();
        $display("%0d input beats sent, %0d event beats checked", items_sent, checked);
        $display("typematic settings used: %0d, delay and rate from zero to all ones",
                 NUM_SETTINGS + 1);
        if (mismatches == 0 && outstanding == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
